>>> rtl/tpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_pkg
// shared types and constants of the trapezoidal profile evaluator
// ----------------------------------------------------------------------------
package tpe_pkg;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_END    = 3'd1,
    REG_SPEED  = 3'd2,
    REG_ACCEL  = 3'd3,
    REG_DECEL  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_VV, ST_D1, ST_D3, ST_CHK, ST_T1, ST_T3, ST_T2,
    ST_AA, ST_PP, ST_PS, ST_DV, ST_SQ, ST_TE
  } setup_state_t;

  localparam int unsigned OP_W = 25;  // narrow operand width for the ramp squares

  // profile figures, fixed between configuration writes
  typedef struct packed {
    logic        fwd;
    logic [31:0] dist_x;
    logic [31:0] pos_b;
    logic [31:0] pos_e;
    logic [31:0] spd;
    logic [31:0] acc1;
    logic [31:0] acc2;
    logic [31:0] d1;
    logic [47:0] t1;
    logic [48:0] t12;
    logic [49:0] te;
    logic [31:0] total;
  } prm_t;

endpackage
`default_nettype wire

>>> rtl/tpe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_div
// restoring divider, one quotient bit per cycle, saturates to all ones
// ----------------------------------------------------------------------------
module tpe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] num_hi,
  input  wire logic [63:0] num_lo,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic        busy;
  logic [6:0]  cnt;
  logic [32:0] rem;
  logic [63:0] sh;
  logic [33:0] trial;
  logic        ge;
  logic [33:0] diff;

  assign trial = {rem, sh[63]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num_hi >= den) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          cnt  <= 7'd64;
        end
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      sh  <= num_lo;
      quo <= (num_hi >= den) ? '1 : '0;
    end else if (busy) begin
      rem <= ge ? diff[32:0] : trial[32:0];
      sh  <= {sh[62:0], 1'b0};
      quo <= {quo[62:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> rtl/tpe_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tpe_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] rad,
  output logic             done,
  output logic [31:0]      root
);
  logic        busy;
  logic [4:0]  k;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] sum;

  assign bitv = 64'd1 << {k, 1'b0};
  assign sum  = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= 5'd31;
      end else if (busy) begin
        k <= k - 5'd1;
        if (k == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v   <= rad;
      res <= '0;
    end else if (busy) begin
      if (v >= sum) begin
        v   <= v - sum;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/tpe_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_setup
// works out ramp distances and phase times from the configuration
// ----------------------------------------------------------------------------
module tpe_setup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] start_position,
  input  wire logic [31:0] end_position,
  input  wire logic [31:0] cruise_speed,
  input  wire logic [31:0] accel_rate,
  input  wire logic [31:0] decel_rate,
  output logic             busy,
  output tpe_pkg::prm_t    prm
);
  import tpe_pkg::*;

  setup_state_t state, state_next;
  logic         fresh;

  logic         fwd;
  logic [31:0]  x, v, a1, a2, num;
  logic [63:0]  vv, d1, d3, aa, rad;
  logic [64:0]  pl, ph;
  logic [96:0]  prod;
  logic [47:0]  t1, t2, t3;
  logic         trap;

  logic         div_start, sq_start, div_done, sq_done;
  logic [32:0]  div_hi, div_den;
  logic [63:0]  div_lo, quo;
  logic [31:0]  root;
  logic [32:0]  diff_f, diff_b;
  logic [31:0]  rem_x;
  logic [49:0]  te_sum;

  tpe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num_hi(div_hi), .num_lo(div_lo),
    .den(div_den), .done(div_done), .quo(quo)
  );

  tpe_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(rad), .done(sq_done), .root(root)
  );

  assign busy   = (state != ST_IDLE);
  assign diff_f = {end_position[31], end_position} - {start_position[31], start_position};
  assign diff_b = {start_position[31], start_position} - {end_position[31], end_position};
  assign rem_x  = x - d1[31:0] - d3[31:0];
  assign te_sum = {2'b0, t1} + {2'b0, t2} + {2'b0, t3};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_PREP;
      ST_PREP: state_next = ST_VV;
      ST_VV:   state_next = ST_D1;
      ST_D1:   if (div_done) state_next = ST_D3;
      ST_D3:   if (div_done) state_next = ST_CHK;
      ST_CHK:  state_next = ((d1 <= {32'd0, x}) && (d3 <= ({32'd0, x} - d1))) ? ST_T1 : ST_AA;
      ST_T1:   if (div_done) state_next = ST_T3;
      ST_T3:   if (div_done) state_next = trap ? ST_T2 : ST_TE;
      ST_T2:   if (div_done) state_next = ST_TE;
      ST_AA:   state_next = ST_PP;
      ST_PP:   state_next = ST_PS;
      ST_PS:   state_next = ST_DV;
      ST_DV:   if (div_done) state_next = ST_SQ;
      ST_SQ:   if (sq_done) state_next = ST_T1;
      ST_TE:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // divider and root unit operands
  always_comb begin
    div_start = 1'b0;
    sq_start  = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_den   = {1'b0, v};
    unique case (state)
      ST_D1: begin
        div_start = fresh;
        div_lo    = vv;
        div_den   = {a1, 1'b0};
      end
      ST_D3: begin
        div_start = fresh;
        div_lo    = vv;
        div_den   = {a2, 1'b0};
      end
      ST_T1: begin
        div_start = fresh;
        div_lo    = {16'd0, num, 16'd0};
        div_den   = {1'b0, a1};
      end
      ST_T3: begin
        div_start = fresh;
        div_lo    = {16'd0, num, 16'd0};
        div_den   = {1'b0, a2};
      end
      ST_T2: begin
        div_start = fresh;
        div_lo    = {16'd0, rem_x, 16'd0};
        div_den   = {1'b0, v};
      end
      ST_DV: begin
        div_start = fresh;
        div_hi    = prod[96:64];
        div_lo    = prod[63:0];
        div_den   = {1'b0, a1} + {1'b0, a2};
      end
      ST_SQ: sq_start = fresh;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_PREP: begin
        fwd <= $signed(end_position) > $signed(start_position);
        x   <= ($signed(end_position) > $signed(start_position)) ? diff_f[31:0] : diff_b[31:0];
        v   <= (cruise_speed == '0) ? 32'd1 : cruise_speed;
        if ($signed(end_position) > $signed(start_position)) begin
          a1 <= (accel_rate == '0) ? 32'd1 : accel_rate;
          a2 <= (decel_rate == '0) ? 32'd1 : decel_rate;
        end else begin
          a1 <= (decel_rate == '0) ? 32'd1 : decel_rate;
          a2 <= (accel_rate == '0) ? 32'd1 : accel_rate;
        end
      end
      ST_VV: vv <= v * v;
      ST_D1: if (div_done) d1 <= quo;
      ST_D3: if (div_done) d3 <= quo;
      ST_CHK: begin
        trap <= (d1 <= {32'd0, x}) && (d3 <= ({32'd0, x} - d1));
        num  <= v;
        t2   <= '0;
      end
      ST_T1: if (div_done) t1 <= quo[47:0];
      ST_T3: if (div_done) t3 <= quo[47:0];
      ST_T2: if (div_done) t2 <= quo[47:0];
      ST_AA: aa <= a1 * a2;
      ST_PP: begin
        pl <= aa[31:0] * {x, 1'b0};
        ph <= aa[63:32] * {x, 1'b0};
      end
      ST_PS: prod <= {32'd0, pl} + {ph, 32'd0};
      ST_DV: if (div_done) rad <= quo;
      ST_SQ: if (sq_done) num <= root;
      ST_TE: begin
        prm.fwd    <= fwd;
        prm.dist_x <= x;
        prm.pos_b  <= start_position;
        prm.pos_e  <= end_position;
        prm.spd    <= v;
        prm.acc1   <= a1;
        prm.acc2   <= a2;
        prm.d1     <= d1[31:0];
        prm.t1     <= t1;
        prm.t12    <= {1'b0, t1} + {1'b0, t2};
        prm.te     <= te_sum;
        prm.total  <= (te_sum[49:32] != '0) ? 32'hFFFF_FFFF : te_sum[31:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/tpe_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_eval
// five stage sample pipeline: phase select, two multiply stages, clamp, position
// ----------------------------------------------------------------------------
module tpe_eval (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tpe_pkg::prm_t prm,
  input  wire logic          hold,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata
);
  import tpe_pkg::*;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;

  // entry decode
  logic [31:0]   t;
  logic [49:0]   r_full;
  phase_t        ph0;
  logic [OP_W-1:0] w0;
  logic          big0;

  // stage regs
  phase_t ph1, ph2, ph3, ph4;
  logic          big1, big2, big3;
  logic [OP_W-1:0] w1, w2;
  logic [31:0]   a_1, u1;
  logic [56:0]   m2;
  logic [63:0]   vu2;
  logic [56:0]   m2s;
  logic [56:0]   pl3;
  logic [49:0]   ph3p;
  logic [48:0]   vd3;
  logic [81:0]   prod;
  logic [65:0]   q;
  logic [31:0]   dist4;
  logic [31:0]   pos5;

  assign t      = s_tdata;
  assign r_full = prm.te - {18'd0, t};

  always_comb begin
    if ({16'd0, t} <= prm.t1) begin
      ph0  = PH_ACCEL;
      w0   = t[OP_W-1:0];
      big0 = (t[31:OP_W] != '0);
    end else if ({17'd0, t} <= prm.t12) begin
      ph0  = PH_CRUISE;
      w0   = t[OP_W-1:0];
      big0 = 1'b0;
    end else if ({18'd0, t} <= prm.te) begin
      ph0  = PH_DECEL;
      w0   = r_full[OP_W-1:0];
      big0 = (r_full[49:OP_W] != '0);
    end else begin
      ph0  = PH_DONE;
      w0   = t[OP_W-1:0];
      big0 = 1'b0;
    end
  end

  assign r5       = !m_tvalid || m_tready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign s_tready = r1 && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid && s_tready;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) m_tvalid <= v4;
    end
  end

  // stage 1: phase and operands
  always_ff @(posedge clk) begin
    if (r1) begin
      ph1  <= ph0;
      big1 <= big0;
      w1   <= w0;
      a_1  <= (ph0 == PH_DECEL) ? prm.acc2 : prm.acc1;
      u1   <= t - prm.t1[31:0];
    end
  end

  // stage 2: first products
  always_ff @(posedge clk) begin
    if (r2) begin
      ph2  <= ph1;
      big2 <= big1;
      w2   <= w1;
      m2   <= a_1 * {7'd0, w1};
      vu2  <= prm.spd * u1;
    end
  end

  // deceleration halves before the second product
  assign m2s = (ph2 == PH_DECEL) ? {1'b0, m2[56:1]} : m2;

  // stage 3: second products as two partials
  always_ff @(posedge clk) begin
    if (r3) begin
      ph3  <= ph2;
      big3 <= big2;
      pl3  <= m2s[31:0] * w2;
      ph3p <= m2s[56:32] * w2;
      vd3  <= {17'd0, prm.d1} + {1'b0, vu2[63:16]};
    end
  end

  assign prod = {25'd0, pl3} + {ph3p, 32'd0};
  assign q    = (ph3 == PH_DECEL) ? prod[81:16] : {1'b0, prod[81:17]};

  // stage 4: scale and clamp to the move length
  always_ff @(posedge clk) begin
    if (r4) begin
      ph4 <= ph3;
      if (ph3 == PH_CRUISE) begin
        dist4 <= (vd3 > {17'd0, prm.dist_x}) ? prm.dist_x : vd3[31:0];
      end else begin
        dist4 <= (big3 || (q > {34'd0, prm.dist_x})) ? prm.dist_x : q[31:0];
      end
    end
  end

  always_comb begin
    unique case (ph4)
      PH_ACCEL, PH_CRUISE: pos5 = prm.fwd ? prm.pos_b + dist4 : prm.pos_b - dist4;
      PH_DECEL:            pos5 = prm.fwd ? prm.pos_e - dist4 : prm.pos_e + dist4;
      PH_DONE:             pos5 = prm.pos_e;
      default:             pos5 = prm.pos_e;
    endcase
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (r5) begin
      m_tdata <= {6'd0, ph4, prm.total, pos5};
    end
  end
endmodule
`default_nettype wire

>>> rtl/trapezoid_profile_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// each accepted sample beat passes the five stage pipeline before its result beat
// throughput: one sample per cycle unless the setup pass or m_tready stalls it
// after reset and after every configuration write a setup pass holds s_tready low:
// five divisions for a trapezoid, and when the ramps do not fit, five divisions
// plus a root for the triangular move
// reset: synchronous, active high; registers return to start 0, end 0, rates 1.0
// ----------------------------------------------------------------------------
// trapezoid_profile_eval
// trapezoidal velocity profile: position, move time and phase per sample
// ----------------------------------------------------------------------------
module trapezoid_profile_eval (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample_time
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // position, total_time, phase, zero pad
);
  import tpe_pkg::*;

  logic [31:0] start_position, end_position, cruise_speed, accel_rate, decel_rate;
  logic        dirty;
  logic        setup_busy;
  logic        cfg_fire;
  prm_t        prm;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      end_position   <= '0;
      cruise_speed   <= 32'd65536;
      accel_rate     <= 32'd65536;
      decel_rate     <= 32'd65536;
      dirty          <= 1'b1;
    end else begin
      if (cfg_fire) begin
        dirty <= 1'b1;
        unique case (cfg_index)
          REG_START: start_position <= cfg_data;
          REG_END:   end_position   <= cfg_data;
          REG_SPEED: cruise_speed   <= cfg_data;
          REG_ACCEL: accel_rate     <= cfg_data;
          REG_DECEL: decel_rate     <= cfg_data;
          default: ;
        endcase
      end else if (!setup_busy) begin
        dirty <= 1'b0;
      end
    end
  end

  tpe_setup u_setup (
    .clk(clk), .rst(rst), .start(dirty && !setup_busy),
    .start_position(start_position), .end_position(end_position),
    .cruise_speed(cruise_speed), .accel_rate(accel_rate), .decel_rate(decel_rate),
    .busy(setup_busy), .prm(prm)
  );

  tpe_eval u_eval (
    .clk(clk), .rst(rst), .prm(prm), .hold(dirty || setup_busy),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

`ifndef SYNTH
  a_hold_setup: assert property (@(posedge clk) disable iff (rst)
    (dirty || setup_busy) |-> !s_tready)
    else $error("sample taken during setup pass");

  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[65:64] == PH_DONE)) |-> (m_tdata[31:0] == end_position))
    else $error("finished phase away from end position");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:32] == prm.total))
    else $error("move time beat does not match profile");
`endif
endmodule
`default_nettype wire
